/* hdl/rle_pkg.sv */
package rle_pkg;

    localparam int MAX_PIECE  = 127;
    localparam int LIT_MAX    = 127;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0] RUN_FLAG = 8'h80;

    typedef enum logic
    {
        CMD_CLOSE,
        CMD_END
    } cmd_kind_t;

    typedef struct packed
    {
        cmd_kind_t  kind;
        logic [7:0] value;
        logic [6:0] len;
        logic       flag;
    } cmd_t;

endpackage

/* hdl/rle_front.sv */
module rle_front
    import rle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte[7:0]
    input  logic       s_tlast,
    output logic       push,
    output cmd_t       push_cmd,
    input  logic       full
);

    logic [7:0] rv_reg, rv_next;
    logic [6:0] rl_reg, rl_next;
    cmd_t       pend_reg [3];
    cmd_t       pend_next [3];
    logic [1:0] pn_reg, pn_next;

    logic       accept;
    logic       close1, close2, close3;
    logic [6:0] base_len, after_len;
    logic [7:0] nv;
    cmd_t       c1, c2, c3, ce;

    assign s_tready = (pn_reg == 2'd0);
    assign accept   = s_tvalid && s_tready;
    assign push     = (pn_reg != 2'd0) && !full;
    assign push_cmd = pend_reg[0];

    always_comb
    begin
        close1    = (rl_reg != 7'd0) && (s_tdata != rv_reg);
        base_len  = (rl_reg == 7'd0 || close1) ? 7'd1 : rl_reg + 7'd1;
        nv        = (rl_reg == 7'd0 || close1) ? s_tdata : rv_reg;
        close2    = (base_len == 7'(MAX_PIECE));
        after_len = close2 ? 7'd0 : base_len;
        close3    = s_tlast && (after_len != 7'd0);

        c1 = '{kind: CMD_CLOSE, value: rv_reg, len: rl_reg, flag: 1'b0};
        c2 = '{kind: CMD_CLOSE, value: nv, len: 7'(MAX_PIECE), flag: 1'b0};
        c3 = '{kind: CMD_CLOSE, value: nv, len: after_len, flag: 1'b0};
        ce = '{kind: CMD_END, value: 8'd0, len: 7'd0, flag: s_tlast};

        pend_next = pend_reg;
        pn_next   = pn_reg;
        rv_next   = rv_reg;
        rl_next   = rl_reg;

        if (accept)
        begin
            rv_next = nv;
            rl_next = s_tlast ? 7'd0 : after_len;
            pn_next = 2'd0;
            if (close1)
            begin
                pend_next[pn_next] = c1;
                pn_next = pn_next + 2'd1;
            end
            if (close2)
            begin
                pend_next[pn_next] = c2;
                pn_next = pn_next + 2'd1;
            end
            if (close3)
            begin
                pend_next[pn_next] = c3;
                pn_next = pn_next + 2'd1;
            end
            pend_next[pn_next] = ce;
            pn_next = pn_next + 2'd1;
        end
        else if (push)
        begin
            pend_next[0] = pend_reg[1];
            pend_next[1] = pend_reg[2];
            pn_next = pn_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= '0;
            rl_reg <= '0;
            pn_reg <= '0;
        end
        else
        begin
            rv_reg <= rv_next;
            rl_reg <= rl_next;
            pn_reg <= pn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

/* hdl/rle_cmd_fifo.sv */
module rle_cmd_fifo
    import rle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    cmd_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wp_reg, rp_reg;
    logic [FIFO_AW:0]   cnt_reg;

    assign full    = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign pop_cmd = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

/* hdl/rle_back.sv */
module rle_back
    import rle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  cmd_t        cmd_in,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // packed_bytes[63:0], byte_count[67:64], zero[71:68]
    output logic        m_tlast,
    output logic        m_tuser    // block_done
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_LIT2,
        ST_RUN_HDR,
        ST_RUN_VAL,
        ST_FLUSH_HDR,
        ST_FLUSH_DAT,
        ST_STEP_END
    } state_t;

    state_t      state_reg, state_next;
    state_t      ret_reg, ret_next;
    cmd_t        cmd_reg, cmd_next;
    logic [6:0]  lit_reg, lit_next;
    logic [6:0]  idx_reg, idx_next;
    logic [63:0] word_reg, word_next;
    logic [3:0]  wcnt_reg, wcnt_next;
    logic        mv_reg, mv_next;
    logic [71:0] md_reg, md_next;
    logic        ml_reg, ml_next;
    logic        mu_reg, mu_next;
    logic [7:0]  rd_reg;
    logic [7:0]  lit_mem [LIT_MAX];

    logic        out_free, byte_ok;
    logic        push_byte;
    logic [7:0]  push_val;
    logic        out_load, out_last, out_done;
    logic        mem_we;
    logic [7:0]  mem_wdata;

    assign out_free = !mv_reg || m_tready;
    assign byte_ok  = (wcnt_reg != 4'd8) || out_free;
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;
    assign m_tuser  = mu_reg;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd_next   = cmd_reg;
        lit_next   = lit_reg;
        idx_next   = idx_reg;
        word_next  = word_reg;
        wcnt_next  = wcnt_reg;
        pop        = 1'b0;
        push_byte  = 1'b0;
        push_val   = 8'd0;
        out_load   = 1'b0;
        out_last   = 1'b0;
        out_done   = 1'b0;
        mem_we     = 1'b0;
        mem_wdata  = cmd_reg.value;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    pop      = 1'b1;
                    cmd_next = cmd_in;
                    if (cmd_in.kind == CMD_CLOSE)
                    begin
                        if (cmd_in.len > 7'd2)
                        begin
                            state_next = (lit_reg != 7'd0) ? ST_FLUSH_HDR : ST_RUN_HDR;
                            ret_next   = ST_RUN_HDR;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = cmd_in.value;
                            lit_next  = lit_reg + 7'd1;
                            ret_next  = (cmd_in.len == 7'd2) ? ST_LIT2 : ST_IDLE;
                            state_next = (lit_next == 7'(LIT_MAX)) ? ST_FLUSH_HDR : ret_next;
                        end
                    end
                    else
                    begin
                        ret_next   = ST_STEP_END;
                        state_next = (cmd_in.flag && lit_reg != 7'd0) ? ST_FLUSH_HDR
                                                                      : ST_STEP_END;
                    end
                end
            end
            ST_LIT2:
            begin
                mem_we     = 1'b1;
                lit_next   = lit_reg + 7'd1;
                ret_next   = ST_IDLE;
                state_next = (lit_next == 7'(LIT_MAX)) ? ST_FLUSH_HDR : ST_IDLE;
            end
            ST_RUN_HDR:
            begin
                if (byte_ok)
                begin
                    push_byte  = 1'b1;
                    push_val   = RUN_FLAG | {1'b0, cmd_reg.len};
                    state_next = ST_RUN_VAL;
                end
            end
            ST_RUN_VAL:
            begin
                if (byte_ok)
                begin
                    push_byte  = 1'b1;
                    push_val   = cmd_reg.value;
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH_HDR:
            begin
                if (byte_ok)
                begin
                    push_byte  = 1'b1;
                    push_val   = {1'b0, lit_reg};
                    state_next = ST_FLUSH_DAT;
                end
            end
            ST_FLUSH_DAT:
            begin
                if (byte_ok)
                begin
                    push_byte = 1'b1;
                    push_val  = rd_reg;
                    if (idx_reg == lit_reg - 7'd1)
                    begin
                        lit_next   = 7'd0;
                        idx_next   = 7'd0;
                        state_next = ret_reg;
                    end
                    else
                    begin
                        idx_next = idx_reg + 7'd1;
                    end
                end
            end
            ST_STEP_END:
            begin
                if (wcnt_reg == 4'd0)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    out_last   = 1'b1;
                    out_done   = cmd_reg.flag;
                    wcnt_next  = 4'd0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (push_byte)
        begin
            if (wcnt_reg == 4'd8 || wcnt_reg == 4'd0)
            begin
                out_load  = (wcnt_reg == 4'd8);
                word_next = {56'd0, push_val};
                wcnt_next = 4'd1;
            end
            else
            begin
                word_next[wcnt_reg[2:0]*8 +: 8] = push_val;
                wcnt_next = wcnt_reg + 4'd1;
            end
        end

        mv_next = mv_reg && !m_tready;
        md_next = md_reg;
        ml_next = ml_reg;
        mu_next = mu_reg;
        if (out_load)
        begin
            mv_next = 1'b1;
            md_next = {4'd0, wcnt_reg, word_reg};
            ml_next = out_last;
            mu_next = out_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lit_mem[lit_reg] <= mem_wdata;
        end
        rd_reg <= lit_mem[idx_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            lit_reg   <= '0;
            idx_reg   <= '0;
            wcnt_reg  <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            lit_reg   <= lit_next;
            idx_reg   <= idx_next;
            wcnt_reg  <= wcnt_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        word_reg <= word_next;
        md_reg   <= md_next;
        ml_reg   <= ml_next;
        mu_reg   <= mu_next;
    end

endmodule

/* hdl/rle_run_literal_encoder.sv */
// Channel  Dir  tdata                                  tlast        tuser
// s        in   data_byte[7:0]                         block_end    -
// m        out  packed_bytes[63:0], byte_count[67:64]  step_end     block_done
//
// Front takes one byte, then pushes each queued command (one to three) into the
// queue before it takes the next byte; pushes wait while the queue is full.
// Back takes each command in ST_IDLE and emits encoded bytes in the run and flush
// states; ST_LIT2 writes the second literal of a pair, ST_STEP_END ends a step.
// Four-entry command queue parts front and back; either stalls alone.
// Reset clears control state only; the literal memory needs no clearing pass.
module rle_run_literal_encoder
    import rle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // packed_bytes[63:0], byte_count[67:64], zero[71:68]
    output logic        m_tlast,
    output logic        m_tuser    // block_done
);

    logic push, full, pop, empty;
    cmd_t push_cmd, pop_cmd;

    rle_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full)
    );

    rle_cmd_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    rle_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!empty),
        .cmd_in    (pop_cmd),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

/* hdl/rle_checker.sv */
module rle_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("word changed while stalled");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[67:64] != 4'd0 && m_tdata[67:64] <= 4'd8)
        else $error("byte count out of range");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[67:64] == 4'd8)
        else $error("partial word before end of step");

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("block done without last");

endmodule

bind rle_run_literal_encoder rle_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
